FILE: rtl/core/pbwp_pkg.sv
// ----------------------------------------------------------------------------
// pbwp_pkg
// Shared constants and types of the Poisson-binomial cluster probability block.
// ----------------------------------------------------------------------------
package pbwp_pkg;

    localparam int DEF_MAX_ALIGNMENTS = 64;
    localparam int DEF_PROB_BITS      = 16;

    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_ALIGN  = 1'b1;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SWEEP,
        B_SUM,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

FILE: rtl/core/poisson_binomial_weighted_prob.sv
// ----------------------------------------------------------------------------
// poisson_binomial_weighted_prob
// Weighted probability of at least one success over a cluster's alignments.
// ----------------------------------------------------------------------------
// Channel   Handshake         Payload
// input     start / busy      kind, align_prob, pair_prob, weight_index,
//                             weight_value, cluster_id, last
// result    done (strobe)     result_cluster, cluster_prob, overflowed
//
// An alignment word is popped and then swept over the distribution memory
// from count n down to 0 through the read and multiply stages, n being its
// new count, until they drain; the last one is followed by the weighted sum
// and the done strobe. A weight word is written to the weight memory on pop.
// A two-word queue lets start be taken while the back part works.
// Reset clears all control and marks every depth weight as 1.0; no sweep.
// The result strobe lasts one cycle and is never held.
// ----------------------------------------------------------------------------
module poisson_binomial_weighted_prob import pbwp_pkg::*; #(
    parameter int MAX_ALIGNMENTS = DEF_MAX_ALIGNMENTS,
    parameter int PROB_BITS      = DEF_PROB_BITS,
    localparam int PW = PROB_BITS + 1,
    localparam int CW = $clog2(MAX_ALIGNMENTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          kind,
    input  logic [PW-1:0] align_prob,
    input  logic [PW-1:0] pair_prob,
    input  logic [CW-1:0] weight_index,
    input  logic [PW-1:0] weight_value,
    input  logic [31:0]   cluster_id,
    input  logic          last,
    output logic          done,
    output logic [31:0]   result_cluster,
    output logic [PW-1:0] cluster_prob,
    output logic          overflowed
);

    localparam int DW = PW + CW + 34;

    queue_stat_t   stat;
    logic          push;
    logic          pop;
    logic [DW-1:0] push_data;
    logic [DW-1:0] head;

    pbwp_front #(
        .MAX_ALIGNMENTS (MAX_ALIGNMENTS),
        .PROB_BITS      (PROB_BITS)
    ) u_front (
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .align_prob   (align_prob),
        .pair_prob    (pair_prob),
        .weight_index (weight_index),
        .weight_value (weight_value),
        .cluster_id   (cluster_id),
        .last         (last),
        .stat         (stat),
        .push         (push),
        .push_data    (push_data)
    );

    pbwp_queue #(
        .DW (DW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    pbwp_back #(
        .MAX_ALIGNMENTS (MAX_ALIGNMENTS),
        .PROB_BITS      (PROB_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .stat           (stat),
        .head           (head),
        .pop            (pop),
        .done           (done),
        .result_cluster (result_cluster),
        .cluster_prob   (cluster_prob),
        .overflowed     (overflowed)
    );

endmodule

FILE: rtl/core/pbwp_front.sv
// ----------------------------------------------------------------------------
// pbwp_front
// Accepts words, saturates probabilities, forms the rounded success chance.
// ----------------------------------------------------------------------------
module pbwp_front import pbwp_pkg::*; #(
    parameter int MAX_ALIGNMENTS = DEF_MAX_ALIGNMENTS,
    parameter int PROB_BITS      = DEF_PROB_BITS,
    localparam int PW = PROB_BITS + 1,
    localparam int CW = $clog2(MAX_ALIGNMENTS + 1),
    localparam int DW = PW + CW + 34
) (
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [PW-1:0]     align_prob,
    input  logic [PW-1:0]     pair_prob,
    input  logic [CW-1:0]     weight_index,
    input  logic [PW-1:0]     weight_value,
    input  logic [31:0]       cluster_id,
    input  logic              last,
    input  queue_stat_t       stat,
    output logic              push,
    output logic [DW-1:0]     push_data
);

    localparam logic [PW-1:0]   ONE  = PW'(1) << PROB_BITS;
    localparam logic [2*PW-1:0] HALF = (2*PW)'(1) << (PROB_BITS - 1);

    logic [PW-1:0]   a_sat;
    logic [PW-1:0]   b_sat;
    logic [PW-1:0]   w_sat;
    logic [2*PW-1:0] prod;
    logic [PW-1:0]   q;
    logic [PW-1:0]   val;

    assign busy  = stat.full;
    assign push  = start && !stat.full;
    assign a_sat = (align_prob > ONE) ? ONE : align_prob;
    assign b_sat = (pair_prob > ONE) ? ONE : pair_prob;
    assign w_sat = (weight_value > ONE) ? ONE : weight_value;
    assign prod  = (2*PW)'(a_sat) * (2*PW)'(b_sat) + HALF;
    assign q     = prod[2*PROB_BITS:PROB_BITS];
    assign val   = (kind == KIND_ALIGN) ? q : w_sat;
    assign push_data = {kind, val, weight_index, cluster_id, last};

endmodule

FILE: rtl/core/pbwp_queue.sv
// ----------------------------------------------------------------------------
// pbwp_queue
// Two-entry word queue between front and back.
// ----------------------------------------------------------------------------
module pbwp_queue import pbwp_pkg::*; #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] head,
    output queue_stat_t   stat
);

    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/core/pbwp_back.sv
// ----------------------------------------------------------------------------
// pbwp_back
// Sweeps the count distribution per alignment and forms the weighted sum.
// ----------------------------------------------------------------------------
module pbwp_back import pbwp_pkg::*; #(
    parameter int MAX_ALIGNMENTS = DEF_MAX_ALIGNMENTS,
    parameter int PROB_BITS      = DEF_PROB_BITS,
    localparam int PW = PROB_BITS + 1,
    localparam int CW = $clog2(MAX_ALIGNMENTS + 1),
    localparam int DW = PW + CW + 34
) (
    input  logic          clk,
    input  logic          rst_n,
    input  queue_stat_t   stat,
    input  logic [DW-1:0] head,
    output logic          pop,
    output logic          done,
    output logic [31:0]   result_cluster,
    output logic [PW-1:0] cluster_prob,
    output logic          overflowed
);

    localparam logic [PW-1:0]   ONE  = PW'(1) << PROB_BITS;
    localparam logic [2*PW-1:0] HALF = (2*PW)'(1) << (PROB_BITS - 1);
    localparam logic [CW-1:0]   MAXC = CW'(MAX_ALIGNMENTS);

    back_state_t state_reg, state_next;

    logic [PW-1:0] dist_mem [MAX_ALIGNMENTS+1];
    logic [PW-1:0] w_mem    [MAX_ALIGNMENTS+1];
    logic          w_valid_reg [MAX_ALIGNMENTS+1];

    logic            h_kind;
    logic [PW-1:0]   h_val;
    logic [CW-1:0]   h_idx;
    logic [31:0]     h_cid;
    logic            h_last;

    logic [CW-1:0]   cnt_reg;
    logic            flag_reg;
    logic [PW-1:0]   q_reg;
    logic [PW-1:0]   nq_reg;
    logic [31:0]     cid_reg;
    logic            last_reg;
    logic            zero_old_reg;
    logic [CW-1:0]   step_reg;
    logic            issue_reg;
    logic [PW-1:0]   upper_reg;
    logic            s1_v_reg;
    logic [CW-1:0]   s1_k_reg;
    logic            s2_v_reg;
    logic [CW-1:0]   s2_k_reg;
    logic [2*PW-1:0] p1_reg;
    logic [2*PW-1:0] p2_reg;
    logic [PW-1:0]   acc_reg;
    logic [PW-1:0]   rd_data_reg;
    logic [PW-1:0]   wd_reg;
    logic            wv_reg;

    logic            drained;
    logic            w_write;
    logic [CW-1:0]   rd_addr;
    logic [PW-1:0]   lower;
    logic [PW-1:0]   wsel;
    logic [2*PW-1:0] m1;
    logic [2*PW-1:0] m2;
    logic [2*PW-1:0] rnd1;
    logic [2*PW-1:0] rnd2;
    logic [PW-1:0]   r1;
    logic [PW-1:0]   r2;
    logic [PW:0]     dsum;
    logic [PW-1:0]   dsat;
    logic [PW:0]     asum;
    logic [PW-1:0]   asat;

    assign h_kind = head[DW-1];
    assign h_val  = head[DW-2 -: PW];
    assign h_idx  = head[CW+32 -: CW];
    assign h_cid  = head[32:1];
    assign h_last = head[0];

    assign drained = !issue_reg && !s1_v_reg && !s2_v_reg;
    assign w_write = pop && (h_kind == KIND_WEIGHT) && (h_idx >= CW'(1)) && (h_idx <= MAXC);
    assign rd_addr = (state_reg == B_SWEEP) ?
                     ((step_reg == '0) ? '0 : step_reg - CW'(1)) : step_reg;

    assign lower = (s1_k_reg == '0) ? '0 :
                   (zero_old_reg && s1_k_reg == CW'(1)) ? ONE : rd_data_reg;
    assign wsel  = wv_reg ? wd_reg : ONE;

    always_comb
    begin
        if (state_reg == B_SWEEP)
        begin
            m1 = (2*PW)'(lower) * (2*PW)'(q_reg);
            m2 = (2*PW)'(upper_reg) * (2*PW)'(nq_reg);
        end
        else
        begin
            m1 = (2*PW)'(rd_data_reg) * (2*PW)'(wsel);
            m2 = '0;
        end
    end

    assign rnd1 = p1_reg + HALF;
    assign rnd2 = p2_reg + HALF;
    assign r1   = rnd1[2*PROB_BITS:PROB_BITS];
    assign r2   = rnd2[2*PROB_BITS:PROB_BITS];
    assign dsum = {1'b0, r1} + {1'b0, r2};
    assign dsat = (dsum > {1'b0, ONE}) ? ONE : dsum[PW-1:0];
    assign asum = {1'b0, acc_reg} + {1'b0, r1};
    assign asat = (asum > {1'b0, ONE}) ? ONE : asum[PW-1:0];

    assign done           = (state_reg == B_OUT);
    assign result_cluster = cid_reg;
    assign cluster_prob   = acc_reg;
    assign overflowed     = flag_reg;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop = 1'b1;
                    if (h_kind == KIND_ALIGN)
                    begin
                        if (cnt_reg < MAXC)
                            state_next = B_SWEEP;
                        else if (h_last)
                            state_next = B_SUM;
                    end
                end
            end
            B_SWEEP:
            begin
                if (drained)
                    state_next = last_reg ? B_SUM : B_IDLE;
            end
            B_SUM:
            begin
                if (drained)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            flag_reg  <= 1'b0;
            issue_reg <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            for (int i = 0; i <= MAX_ALIGNMENTS; i++)
                w_valid_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= issue_reg;
            s2_v_reg  <= s1_v_reg;

            if (issue_reg)
            begin
                if (state_reg == B_SWEEP)
                begin
                    if (step_reg == '0)
                        issue_reg <= 1'b0;
                    else
                        step_reg <= step_reg - CW'(1);
                end
                else
                begin
                    if (step_reg == cnt_reg)
                        issue_reg <= 1'b0;
                    else
                        step_reg <= step_reg + CW'(1);
                end
            end

            if (w_write)
                w_valid_reg[h_idx] <= 1'b1;

            if (pop && h_kind == KIND_ALIGN)
            begin
                cid_reg  <= h_cid;
                last_reg <= h_last;
                if (cnt_reg < MAXC)
                begin
                    q_reg        <= h_val;
                    nq_reg       <= ONE - h_val;
                    zero_old_reg <= (cnt_reg == '0);
                    cnt_reg      <= cnt_reg + CW'(1);
                    step_reg     <= cnt_reg + CW'(1);
                    issue_reg    <= 1'b1;
                    upper_reg    <= '0;
                end
                else
                begin
                    flag_reg <= 1'b1;
                end
            end

            if (state_next == B_SUM && state_reg != B_SUM)
            begin
                step_reg  <= CW'(1);
                issue_reg <= 1'b1;
                acc_reg   <= '0;
            end

            if (issue_reg)
                wv_reg <= w_valid_reg[step_reg];

            if (s1_v_reg)
            begin
                s2_k_reg <= s1_k_reg;
                p1_reg   <= m1;
                p2_reg   <= m2;
                if (state_reg == B_SWEEP)
                    upper_reg <= lower;
            end
            s1_k_reg <= step_reg;

            if (s2_v_reg && state_reg == B_SUM)
                acc_reg <= asat;

            if (state_reg == B_OUT)
            begin
                cnt_reg  <= '0;
                flag_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_reg)
        begin
            rd_data_reg <= dist_mem[rd_addr];
            wd_reg      <= w_mem[step_reg];
        end
        if (s2_v_reg && state_reg == B_SWEEP)
            dist_mem[s2_k_reg] <= dsat;
        if (w_write)
            w_mem[h_idx] <= h_val;
    end

endmodule

FILE: rtl/core/pbwp_checker.sv
// ----------------------------------------------------------------------------
// pbwp_checker
// Port-level checks of result timing and range and of busy, bound to the top level.
// ----------------------------------------------------------------------------
module pbwp_checker import pbwp_pkg::*; #(
    parameter int PROB_BITS = DEF_PROB_BITS,
    localparam int PW = PROB_BITS + 1
) (
    input logic          clk,
    input logic          rst_n,
    input logic          busy,
    input logic          done,
    input logic [PW-1:0] cluster_prob
);

    localparam logic [PW-1:0] ONE = PW'(1) << PROB_BITS;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cluster_prob <= ONE)
        else $error("cluster_prob above 1.0");

    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(done, 2) && !$past(done, 3))
        else $error("results closer than a full sum");

    a_busy_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(busy))
        else $error("busy unknown");

endmodule

bind poisson_binomial_weighted_prob pbwp_checker #(
    .PROB_BITS (PROB_BITS)
) u_pbwp_checker (.*);
